FILE: hw/rtl/chdg_pkg.sv
// Package for the compass heading core: widths, fixed-point constants and the
// sideband struct that travels beside each transaction through the pipeline.
// No dependencies.
`default_nettype none

package chdg_pkg;

    // Width of each signed vector component.
    localparam int CompBits = 16;

    // Ratio t has FracT fractional bits and ranges over 0 .. 2^FracT.
    localparam int FracT = 16;
    localparam int TBits = FracT + 1;

    // Quotient bits produced by the divider, and how many per pipeline stage.
    localparam int DivSteps      = TBits;
    localparam int StepsPerStage = 3;
    localparam int DivStages     = (DivSteps + StepsPerStage - 1) / StepsPerStage;

    // The doubled fit is t * (FitLin * 2^FracT - FitSlope * t), which is the
    // octant angle in degrees with FracA = 2 * FracT + 1 fractional bits.
    localparam int FitLin   = 121;
    localparam int FitSlope = 31;
    localparam int KBits    = FracT + 7;
    localparam int FitBits  = TBits + KBits;
    localparam int FracA    = 2 * FracT + 1;

    // Heading word: nine integer bits cover 0 .. 360 degrees.
    localparam int HBits    = FracA + 9;
    localparam int HeadFrac = 7;
    localparam int HeadBits = 16;
    localparam int OutShift = FracA - HeadFrac;

    // Angles in the wide fixed-point format, with rounding folded in.
    localparam logic [HBits-1:0] RoundHalf = HBits'(1) << (OutShift - 1);
    localparam logic [HBits-1:0] Deg90Q    = HBits'(90) << FracA;
    localparam logic [HBits-1:0] Deg180R   = (HBits'(180) << FracA) + RoundHalf;
    localparam logic [HBits-1:0] Deg360R   = (HBits'(360) << FracA) + RoundHalf;

    // Exact headings on the axes, already in the output format.
    localparam logic [HeadBits-1:0] Head0   = HeadBits'(0);
    localparam logic [HeadBits-1:0] Head90  = HeadBits'(90 << HeadFrac);
    localparam logic [HeadBits-1:0] Head180 = HeadBits'(180 << HeadFrac);
    localparam logic [HeadBits-1:0] Head270 = HeadBits'(270 << HeadFrac);

    // Quadrant and special-case flags carried beside the datapath.
    typedef struct packed {
        logic north_neg;
        logic east_neg;
        logic east_smaller;
        logic east_zero;
        logic north_zero;
    } chdg_side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/chdg_divider.sv
// Pipelined restoring divider: computes (small * 2^FracT) / large, a few
// quotient bits per stage, with per-stage valid bits and local stall control.
// Depends on chdg_pkg.
`default_nettype none

module chdg_divider (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [chdg_pkg::CompBits-1:0]  in_small,
    input  wire logic [chdg_pkg::CompBits-1:0]  in_large,
    input  wire chdg_pkg::chdg_side_t           in_side,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [chdg_pkg::TBits-1:0]          out_quot,
    output chdg_pkg::chdg_side_t                out_side
);

    localparam int Last = chdg_pkg::DivStages - 1;

    logic [chdg_pkg::DivStages-1:0] v_reg;
    logic [chdg_pkg::DivStages-1:0] ld;
    logic [chdg_pkg::CompBits-1:0]  rem_reg   [chdg_pkg::DivStages];
    logic [chdg_pkg::CompBits-1:0]  large_reg [chdg_pkg::DivStages];
    logic [chdg_pkg::TBits-1:0]     quot_reg  [chdg_pkg::DivStages];
    chdg_pkg::chdg_side_t           side_reg  [chdg_pkg::DivStages];

    // A stage loads when it is empty or when its contents move on.
    always_comb
    begin
        ld[Last] = !v_reg[Last] || out_ready;
        for (int s = Last - 1; s >= 0; s--)
        begin
            ld[s] = !v_reg[s] || ld[s+1];
        end
    end

    assign in_ready = ld[0];

    genvar gs;
    generate
        for (gs = 0; gs < chdg_pkg::DivStages; gs++)
        begin : g_stage
            logic                          src_valid;
            logic [chdg_pkg::CompBits-1:0] src_rem;
            logic [chdg_pkg::CompBits-1:0] src_large;
            logic [chdg_pkg::TBits-1:0]    src_quot;
            chdg_pkg::chdg_side_t          src_side;
            logic [chdg_pkg::CompBits:0]   trial;
            logic [chdg_pkg::CompBits-1:0] rem_next;
            logic [chdg_pkg::TBits-1:0]    quot_next;

            // The first stage takes the transaction from the ports.
            if (gs == 0)
            begin : g_src_in
                assign src_valid = in_valid;
                assign src_rem   = in_small;
                assign src_large = in_large;
                assign src_quot  = '0;
                assign src_side  = in_side;
            end
            else
            begin : g_src_prev
                assign src_valid = v_reg[gs-1];
                assign src_rem   = rem_reg[gs-1];
                assign src_large = large_reg[gs-1];
                assign src_quot  = quot_reg[gs-1];
                assign src_side  = side_reg[gs-1];
            end

            // Trial subtractions; the very first step compares without a shift.
            always_comb
            begin
                trial     = '0;
                rem_next  = src_rem;
                quot_next = src_quot;
                for (int m = 0; m < chdg_pkg::StepsPerStage; m++)
                begin
                    if (gs * chdg_pkg::StepsPerStage + m < chdg_pkg::DivSteps)
                    begin
                        if (gs * chdg_pkg::StepsPerStage + m == 0)
                        begin
                            trial = {1'b0, rem_next};
                        end
                        else
                        begin
                            trial = {rem_next, 1'b0};
                        end
                        if (trial >= {1'b0, src_large})
                        begin
                            trial     = trial - {1'b0, src_large};
                            quot_next = {quot_next[chdg_pkg::TBits-2:0], 1'b1};
                        end
                        else
                        begin
                            quot_next = {quot_next[chdg_pkg::TBits-2:0], 1'b0};
                        end
                        rem_next = trial[chdg_pkg::CompBits-1:0];
                    end
                end
            end

            // Valid bit of this stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[gs] <= 1'b0;
                end
                else if (ld[gs])
                begin
                    v_reg[gs] <= src_valid;
                end
            end

            // Payload of this stage.
            always_ff @(posedge clk)
            begin
                if (ld[gs] && src_valid)
                begin
                    rem_reg[gs]   <= rem_next;
                    large_reg[gs] <= src_large;
                    quot_reg[gs]  <= quot_next;
                    side_reg[gs]  <= src_side;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[Last];
    assign out_quot  = quot_reg[Last];
    assign out_side  = side_reg[Last];

endmodule

`default_nettype wire

FILE: hw/rtl/compass_heading_atan2_approx_core.sv
// Compass heading core: heading clockwise from north in Q9.7 degrees from
// signed north and east components, using a quadratic arctangent fit.
// Depends on chdg_pkg and chdg_divider.
// Stages in order: magnitudes, the divider stages, then fit, multiply,
// angle and output; every stage has its own valid bit.
// Throughput is one transaction per cycle while heading_ready is high.
// Reset clears only the valid bits; the pipeline comes out of reset empty.
`default_nettype none

module compass_heading_atan2_approx_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    output logic                                       item_ready,
    input  wire logic signed [chdg_pkg::CompBits-1:0]  north_component,
    input  wire logic signed [chdg_pkg::CompBits-1:0]  east_component,
    output logic                                       heading_valid,
    input  wire logic                                  heading_ready,
    output logic [chdg_pkg::HeadBits-1:0]              heading_q7
);

    // Magnitude stage.
    logic                          mag_v_reg;
    logic [chdg_pkg::CompBits-1:0] small_reg;
    logic [chdg_pkg::CompBits-1:0] large_reg;
    chdg_pkg::chdg_side_t          mag_side_reg;
    logic [chdg_pkg::CompBits-1:0] north_mag;
    logic [chdg_pkg::CompBits-1:0] east_mag;
    chdg_pkg::chdg_side_t          side_next;

    // Divider outputs.
    logic                          div_in_ready;
    logic                          div_valid;
    logic                          div_ready;
    logic [chdg_pkg::TBits-1:0]    div_quot;
    chdg_pkg::chdg_side_t          div_side;

    // Fit factor stage.
    logic                          k_v_reg;
    logic [chdg_pkg::TBits-1:0]    t_reg;
    logic [chdg_pkg::KBits-1:0]    k_reg;
    chdg_pkg::chdg_side_t          k_side_reg;
    logic [chdg_pkg::KBits-1:0]    k_next;

    // Multiply stage.
    logic                          mul_v_reg;
    logic [chdg_pkg::FitBits-1:0]  fit_reg;
    chdg_pkg::chdg_side_t          mul_side_reg;

    // Octant angle stage.
    logic                          ang_v_reg;
    logic [chdg_pkg::HBits-1:0]    ang_reg;
    chdg_pkg::chdg_side_t          ang_side_reg;
    logic [chdg_pkg::HBits-1:0]    ang_next;

    // Output stage.
    logic                          out_v_reg;
    logic [chdg_pkg::HeadBits-1:0] heading_reg;
    logic [chdg_pkg::HeadBits-1:0] heading_next;
    logic [chdg_pkg::HBits-1:0]    h_round;

    // Stage load enables: a stage loads when empty or when it drains.
    logic ld_mag;
    logic ld_k;
    logic ld_mul;
    logic ld_ang;
    logic ld_out;

    assign ld_out     = !out_v_reg || heading_ready;
    assign ld_ang     = !ang_v_reg || ld_out;
    assign ld_mul     = !mul_v_reg || ld_ang;
    assign ld_k       = !k_v_reg || ld_mul;
    assign div_ready  = ld_k;
    assign ld_mag     = !mag_v_reg || div_in_ready;
    assign item_ready = ld_mag;

    // Magnitudes, quadrant signs and ordering of the two components.
    always_comb
    begin
        north_mag = north_component[chdg_pkg::CompBits-1]
                  ? (~north_component) + chdg_pkg::CompBits'(1)
                  : north_component;
        east_mag  = east_component[chdg_pkg::CompBits-1]
                  ? (~east_component) + chdg_pkg::CompBits'(1)
                  : east_component;
        side_next.north_neg    = north_component[chdg_pkg::CompBits-1];
        side_next.east_neg     = east_component[chdg_pkg::CompBits-1];
        side_next.east_smaller = east_mag < north_mag;
        side_next.east_zero    = east_mag == '0;
        side_next.north_zero   = north_mag == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_v_reg <= 1'b0;
        end
        else if (ld_mag)
        begin
            mag_v_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_mag && item_valid)
        begin
            small_reg    <= side_next.east_smaller ? east_mag : north_mag;
            large_reg    <= side_next.east_smaller ? north_mag : east_mag;
            mag_side_reg <= side_next;
        end
    end

    // Ratio t = small * 2^FracT / large, truncated.
    chdg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mag_v_reg),
        .in_ready  (div_in_ready),
        .in_small  (small_reg),
        .in_large  (large_reg),
        .in_side   (mag_side_reg),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Second factor of the doubled fit: FitLin * 2^FracT - FitSlope * t.
    assign k_next = (chdg_pkg::KBits'(chdg_pkg::FitLin) << chdg_pkg::FracT)
                  - chdg_pkg::KBits'(chdg_pkg::FitSlope) * chdg_pkg::KBits'(div_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_v_reg <= 1'b0;
        end
        else if (ld_k)
        begin
            k_v_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_k && div_valid)
        begin
            t_reg      <= div_quot;
            k_reg      <= k_next;
            k_side_reg <= div_side;
        end
    end

    // Fit product: the octant angle in degrees with FracA fractional bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
        end
        else if (ld_mul)
        begin
            mul_v_reg <= k_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_mul && k_v_reg)
        begin
            fit_reg      <= chdg_pkg::FitBits'(t_reg) * chdg_pkg::FitBits'(k_reg);
            mul_side_reg <= k_side_reg;
        end
    end

    // Octant angle: the fit itself, or its complement to 90 degrees.
    assign ang_next = mul_side_reg.east_smaller
                    ? chdg_pkg::HBits'(fit_reg)
                    : chdg_pkg::Deg90Q - chdg_pkg::HBits'(fit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_v_reg <= 1'b0;
        end
        else if (ld_ang)
        begin
            ang_v_reg <= mul_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_ang && mul_v_reg)
        begin
            ang_reg      <= ang_next;
            ang_side_reg <= mul_side_reg;
        end
    end

    // Quadrant placement with rounding folded into the base angle, then the
    // axis cases, which bypass the fit entirely.
    always_comb
    begin
        if (ang_side_reg.east_neg)
        begin
            h_round = ang_side_reg.north_neg ? chdg_pkg::Deg180R + ang_reg
                                             : chdg_pkg::Deg360R - ang_reg;
        end
        else
        begin
            h_round = ang_side_reg.north_neg ? chdg_pkg::Deg180R - ang_reg
                                             : ang_reg + chdg_pkg::RoundHalf;
        end

        if (ang_side_reg.east_zero)
        begin
            heading_next = ang_side_reg.north_neg ? chdg_pkg::Head180 : chdg_pkg::Head0;
        end
        else if (ang_side_reg.north_zero)
        begin
            heading_next = ang_side_reg.east_neg ? chdg_pkg::Head270 : chdg_pkg::Head90;
        end
        else
        begin
            heading_next = h_round[chdg_pkg::HBits-1:chdg_pkg::OutShift];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            out_v_reg <= ang_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out && ang_v_reg)
        begin
            heading_reg <= heading_next;
        end
    end

    assign heading_valid = out_v_reg;
    assign heading_q7    = heading_reg;

endmodule

`default_nettype wire

FILE: tb/chdg_heading_compare.sv
// Heading comparison for the compass heading core: watches both channels,
// predicts every heading from the accepted components and compares in order.
// Depends on chdg_pkg for the component and heading widths and the fractional bit counts.
module chdg_heading_compare (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    input  logic                                  item_ready,
    input  logic signed [chdg_pkg::CompBits-1:0]  north_component,
    input  logic signed [chdg_pkg::CompBits-1:0]  east_component,
    input  logic                                  heading_valid,
    input  logic                                  heading_ready,
    input  logic [chdg_pkg::HeadBits-1:0]         heading_q7,
    output int                                    mismatch_count,
    output int                                    pending_headings
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CompW  = chdg_pkg::CompBits;
    localparam int RatioF = chdg_pkg::FracT;
    localparam int AngleF = chdg_pkg::FracA;
    localparam int HeadW  = chdg_pkg::HeadBits;
    localparam int HeadF  = chdg_pkg::HeadFrac;

    // Angles in degrees with AngleF fractional bits.
    localparam logic [63:0] AngleOne = 64'd1 << AngleF;
    localparam logic [63:0] Angle90  = 64'd90 * AngleOne;
    localparam logic [63:0] Angle180 = 64'd180 * AngleOne;
    localparam logic [63:0] Angle270 = 64'd270 * AngleOne;
    localparam logic [63:0] Angle360 = 64'd360 * AngleOne;
    localparam logic [63:0] RatioOne = 64'd1 << RatioF;

    logic [HeadW-1:0] expected_headings[$];
    logic [HeadW-1:0] oldest_heading;

    initial begin
        mismatch_count   = 0;
        pending_headings = 0;
    end

    // Heading for one pair of components, rounded to the nearest 1/128 degree.
    function automatic logic [HeadW-1:0] predict_heading(
        input logic signed [CompW-1:0] north,
        input logic signed [CompW-1:0] east
    );
        logic        north_neg, east_neg, east_minor;
        logic [63:0] north_mag, east_mag, minor_mag, major_mag;
        logic [63:0] ratio, fit, octant, angle;
        north_neg = north[CompW-1];
        east_neg  = east[CompW-1];
        north_mag = north_neg ? ((64'd1 << CompW) - 64'(unsigned'(north)))
                              : 64'(unsigned'(north));
        east_mag  = east_neg ? ((64'd1 << CompW) - 64'(unsigned'(east)))
                             : 64'(unsigned'(east));

        if (east_mag == 0) begin
            angle = north_neg ? Angle180 : 64'd0;
        end
        else if (north_mag == 0) begin
            angle = east_neg ? Angle270 : Angle90;
        end
        else begin
            // Ratio of the smaller magnitude to the larger, truncated.
            east_minor = east_mag < north_mag;
            minor_mag  = east_minor ? east_mag : north_mag;
            major_mag  = east_minor ? north_mag : east_mag;
            ratio      = (minor_mag << RatioF) / major_mag;
            // Doubled quadratic fit lands directly on AngleF fractional bits.
            fit    = 64'd90 * ratio * RatioOne + 64'd31 * ratio * (RatioOne - ratio);
            octant = east_minor ? fit : Angle90 - fit;
            // Place the octant angle into its quadrant.
            if (!east_neg)
                angle = north_neg ? Angle180 - octant : octant;
            else
                angle = north_neg ? Angle180 + octant : Angle360 - octant;
        end

        angle = (angle + (64'd1 << (AngleF - HeadF - 1))) >> (AngleF - HeadF);
        return angle[HeadW-1:0];
    endfunction

    // Retire the oldest expectation before queueing a new one: a heading
    // leaving at this edge always belongs to an earlier transaction.
    always @(posedge clk) begin
        if (rst_n) begin
            if (heading_valid && heading_ready) begin
                if (expected_headings.size() == 0) begin
                    $display("%0t: unexpected heading transaction, actual %0d",
                             $time, heading_q7);
                    mismatch_count++;
                end
                else begin
                    oldest_heading = expected_headings.pop_front();
                    if (heading_q7 !== oldest_heading) begin
                        $display("%0t: heading_q7 mismatch, expected %0d, actual %0d",
                                 $time, oldest_heading, heading_q7);
                        mismatch_count++;
                    end
                end
            end
            if (item_valid && item_ready)
                expected_headings.push_back(predict_heading(north_component,
                                                            east_component));
            pending_headings = expected_headings.size();
        end
    end

endmodule

FILE: tb/compass_heading_atan2_approx_core_tb.sv
// Testbench top for the compass heading core: drives directed and random
// component pairs with random gaps and back-pressure, and reports the verdict.
// Depends on chdg_pkg, the core, and chdg_heading_compare.
module compass_heading_atan2_approx_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CompW       = chdg_pkg::CompBits;
    localparam int RandomPairs = 450;
    localparam int TailCycles  = 40;
    localparam int CycleLimit  = 300000;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_ready;
    logic signed [CompW-1:0]  north_component;
    logic signed [CompW-1:0]  east_component;
    logic                     heading_valid;
    logic                     heading_ready;
    logic [chdg_pkg::HeadBits-1:0] heading_q7;
    int                       mismatch_count;
    int                       pending_headings;
    int                       cycle_count;
    int                       sent_pairs;
    int                       taken_headings;

    compass_heading_atan2_approx_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .north_component (north_component),
        .east_component  (east_component),
        .heading_valid   (heading_valid),
        .heading_ready   (heading_ready),
        .heading_q7      (heading_q7)
    );

    chdg_heading_compare u_compare (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .north_component  (north_component),
        .east_component   (east_component),
        .heading_valid    (heading_valid),
        .heading_ready    (heading_ready),
        .heading_q7       (heading_q7),
        .mismatch_count   (mismatch_count),
        .pending_headings (pending_headings)
    );

    // Clock with a 20 ns period.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit in case a handshake never completes.
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Wait drawn per transaction; every third stretch of 40 runs with no idling.
    function automatic int draw_gap(input int index);
        if ((index / 40) % 3 == 2)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // Build a component from a magnitude and a sign; 32768 wraps to the most
    // negative value either way.
    function automatic logic signed [CompW-1:0] with_sign(input int mag, input bit neg);
        return CompW'(neg ? -mag : mag);
    endfunction

    // Offer one pair and hold it until the core takes it.
    task automatic send_pair(input logic signed [CompW-1:0] north,
                             input logic signed [CompW-1:0] east);
        int gap;
        gap = draw_gap(sent_pairs);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid      <= 1'b1;
        north_component <= north;
        east_component  <= east;
        do @(posedge clk); while (!item_ready);
        sent_pairs++;
    endtask

    // One random pair from a mix of shapes that stress the octant logic.
    task automatic send_random_pair();
        int mag_a, mag_b;
        bit sign_a, sign_b;
        int edges[5];
        edges = '{-32768, -1, 0, 1, 32767};
        mag_a  = $urandom_range(1, 32768);
        mag_b  = $urandom_range(1, 32768);
        sign_a = $urandom_range(0, 1);
        sign_b = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            5:       send_pair(CompW'(int'($urandom_range(0, 8)) - 4),
                               CompW'(int'($urandom_range(0, 8)) - 4));
            6: begin
                // On an axis.
                if (sign_b)
                    send_pair(with_sign(mag_a, sign_a), '0);
                else
                    send_pair('0, with_sign(mag_a, sign_a));
            end
            // Equal magnitudes in a random quadrant.
            7:       send_pair(with_sign(mag_a, sign_a), with_sign(mag_a, sign_b));
            8: begin
                // Close to an axis: one large component, one tiny.
                mag_b = $urandom_range(1, 3);
                if ($urandom_range(0, 1))
                    send_pair(with_sign(mag_a, sign_a), with_sign(mag_b, sign_b));
                else
                    send_pair(with_sign(mag_b, sign_a), with_sign(mag_a, sign_b));
            end
            9:       send_pair(CompW'(edges[$urandom_range(0, 4)]),
                               CompW'(edges[$urandom_range(0, 4)]));
            default: send_pair(CompW'($urandom), CompW'($urandom));
        endcase
    endtask

    // Heading side: random stalls before each transaction.
    initial begin
        heading_ready  <= 1'b0;
        taken_headings = 0;
        forever begin
            int gap;
            gap = draw_gap(taken_headings + 20);
            if (gap > 0) begin
                heading_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            heading_ready <= 1'b1;
            do @(posedge clk); while (!heading_valid);
            taken_headings++;
        end
    end

    // Reset, stimulus, drain and verdict.
    initial begin
        rst_n           <= 1'b0;
        item_valid      <= 1'b0;
        north_component <= '0;
        east_component  <= '0;
        sent_pairs      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero vector and the four axes at full scale and at unit size.
        send_pair(0, 0);
        send_pair(32767, 0);
        send_pair(-32768, 0);
        send_pair(0, 32767);
        send_pair(0, -32768);
        send_pair(1, 0);
        send_pair(-1, 0);
        send_pair(0, 1);
        send_pair(0, -1);
        // Equal or nearly equal magnitudes in every quadrant, including the most negative value.
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        send_pair(32767, -32768);
        send_pair(-32768, 32767);
        send_pair(1, 1);
        send_pair(-1, -1);
        send_pair(1, -1);
        send_pair(-1, 1);
        // Near the axes: tiny angles, a heading that rounds up to 360, then two general pairs.
        send_pair(32767, -1);
        send_pair(32767, 1);
        send_pair(-32768, 1);
        send_pair(-32768, -1);
        send_pair(1, 32767);
        send_pair(-1, -32768);
        send_pair(12345, -23456);
        send_pair(-30000, 20000);

        repeat (RandomPairs) send_random_pair();
        item_valid <= 1'b0;

        while (pending_headings != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: compass_heading_atan2_approx_core.f
hw/rtl/chdg_pkg.sv
hw/rtl/chdg_divider.sv
hw/rtl/compass_heading_atan2_approx_core.sv
tb/chdg_heading_compare.sv
tb/compass_heading_atan2_approx_core_tb.sv
